/* rtl/core/rcitp_pkg.sv */
// Package for the repeat-count integer token parser.
// Holds the parser state and result types, the character and error codes
// and the saturation limit. It depends on nothing.
package rcitp_pkg;

   localparam logic [1:0] PHASE_START   = 2'd0;
   localparam logic [1:0] PHASE_SIGN    = 2'd1;
   localparam logic [1:0] PHASE_DIGITS  = 2'd2;
   localparam logic [1:0] PHASE_STOPPED = 2'd3;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_MISSING = 2'd1;
   localparam logic [1:0] ERR_RANGE   = 2'd2;

   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [32:0] MAG_CAP     = 33'h0_8000_0001;
   localparam logic [32:0] LIMIT_POS   = 33'h0_7FFF_FFFF;
   localparam logic [32:0] LIMIT_NEG   = 33'h0_8000_0000;

   typedef struct packed {
      logic        in_token;
      logic        after_star;
      logic [1:0]  number_phase;
      logic        negative_sign;
      logic [32:0] accumulator;
      logic [31:0] saved_count;
      logic [1:0]  error_code;
   } state_type;

   typedef struct packed {
      logic [31:0] token_value;
      logic [30:0] repeat_count;
      logic [1:0]  parse_error;
      logic        buffer_done;
   } result_type;

endpackage

/* rtl/core/repeat_count_integer_token_parser.sv */
// Top level of the repeat-count integer token parser.
// Holds the parser state and the result register; the per-byte logic
// lives in rcitp_step and the types in rcitp_pkg.

// The parser takes one text byte per cycle and splits the text into tokens
// at whitespace; each token, plain V or N*V, yields one result beat in the
// cycle after the byte that closes it. The rate, when not stalled, is one
// byte per cycle, set by the single decimal multiply-add that updates the
// accumulator for each byte; req_tready falls only while a result beat waits
// and rsp_tready is low. Errors return zero value and count, and the final
// byte of a buffer always leaves the parser in its reset state.
module repeat_count_integer_token_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_code
   input  logic        req_tlast,  // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // [31:0] token_value, [62:32] repeat_count, [63] zero
   output logic [1:0]  rsp_tuser,  // [1:0] parse_error
   output logic        rsp_tlast   // buffer_done
);

   rcitp_pkg::state_type  state_ff, state_in;
   rcitp_pkg::result_type result_ff, step_result;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  step_valid;
   logic                  req_accept;

   rcitp_step u_step (
      .cur_state     (state_ff),
      .char_code     (req_tdata),
      .end_of_buffer (req_tlast),
      .nxt_state     (state_in),
      .result        (step_result),
      .result_valid  (step_valid)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && step_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && step_valid) begin
         result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.repeat_count, result_ff.token_value};
   assign rsp_tuser  = result_ff.parse_error;
   assign rsp_tlast  = result_ff.buffer_done;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rcitp_pkg::ERR_NONE |-> rsp_tdata == 64'd0)
      else $error("error result carries non-zero value or count");

   a_buffer_reset: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> state_ff == '0)
      else $error("parser state not cleared after final byte");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined error code on result");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with an empty result register");

endmodule

/* rtl/core/rcitp_step.sv */
// Next-state and result logic for one byte of the token parser.
// Purely combinational; uses the state and result types of rcitp_pkg.
module rcitp_step (
   input  rcitp_pkg::state_type  cur_state,
   input  logic [7:0]            char_code,
   input  logic                  end_of_buffer,
   output rcitp_pkg::state_type  nxt_state,
   output rcitp_pkg::result_type result,
   output logic                  result_valid
);

   function automatic logic [1:0] part_error(rcitp_pkg::state_type s);
      logic [32:0] limit;
      limit = s.negative_sign ? rcitp_pkg::LIMIT_NEG : rcitp_pkg::LIMIT_POS;
      if (s.error_code != rcitp_pkg::ERR_NONE) begin
         return s.error_code;
      end else if (s.number_phase == rcitp_pkg::PHASE_START ||
                   s.number_phase == rcitp_pkg::PHASE_SIGN) begin
         return rcitp_pkg::ERR_MISSING;
      end else if (s.accumulator > limit) begin
         return rcitp_pkg::ERR_RANGE;
      end
      return rcitp_pkg::ERR_NONE;
   endfunction

   function automatic logic [31:0] part_value(rcitp_pkg::state_type s);
      logic [31:0] mag;
      mag = s.accumulator[31:0];
      return s.negative_sign ? (32'd0 - mag) : mag;
   endfunction

   logic        is_space;
   logic        is_digit;
   logic [35:0] acc_sum;
   logic [31:0] count_value;
   logic [31:0] close_value;
   logic [31:0] close_count;
   logic [1:0]  close_error;
   rcitp_pkg::state_type st;

   assign is_space = (char_code == rcitp_pkg::CHAR_SPACE) ||
                     (char_code >= rcitp_pkg::CHAR_TAB && char_code <= rcitp_pkg::CHAR_CR);
   assign is_digit = (char_code >= rcitp_pkg::CHAR_ZERO) &&
                     (char_code <= rcitp_pkg::CHAR_NINE);
   assign acc_sum  = ({3'b000, cur_state.accumulator} << 3) +
                     ({3'b000, cur_state.accumulator} << 1) +
                     {32'd0, 4'(char_code - rcitp_pkg::CHAR_ZERO)};

   always_comb begin
      st           = cur_state;
      count_value  = part_value(cur_state);
      close_value  = 32'd0;
      close_count  = 32'd0;
      close_error  = rcitp_pkg::ERR_NONE;
      result       = '0;
      result_valid = 1'b0;

      if (!is_space) begin
         if (char_code == rcitp_pkg::CHAR_STAR && st.in_token && !st.after_star) begin
            st.error_code    = part_error(cur_state);
            st.saved_count   = count_value[31] ? 32'd0 : count_value;
            st.after_star    = 1'b1;
            st.number_phase  = rcitp_pkg::PHASE_START;
            st.negative_sign = 1'b0;
            st.accumulator   = '0;
         end else begin
            if (is_digit) begin
               if (st.number_phase != rcitp_pkg::PHASE_STOPPED) begin
                  st.accumulator  = (acc_sum > {3'b000, rcitp_pkg::MAG_CAP}) ?
                                    rcitp_pkg::MAG_CAP : acc_sum[32:0];
                  st.number_phase = rcitp_pkg::PHASE_DIGITS;
               end
            end else if (st.number_phase == rcitp_pkg::PHASE_START &&
                         (char_code == rcitp_pkg::CHAR_PLUS ||
                          char_code == rcitp_pkg::CHAR_MINUS)) begin
               st.negative_sign = (char_code == rcitp_pkg::CHAR_MINUS);
               st.number_phase  = rcitp_pkg::PHASE_SIGN;
            end else begin
               if ((st.number_phase == rcitp_pkg::PHASE_START ||
                    st.number_phase == rcitp_pkg::PHASE_SIGN) &&
                   st.error_code == rcitp_pkg::ERR_NONE) begin
                  st.error_code = rcitp_pkg::ERR_MISSING;
               end
               st.number_phase = rcitp_pkg::PHASE_STOPPED;
            end
            st.in_token = 1'b1;
         end
      end

      if (st.in_token && (is_space || end_of_buffer)) begin
         close_error = part_error(st);
         close_value = part_value(st);
         close_count = st.after_star ? st.saved_count : 32'd1;
         if (close_error != rcitp_pkg::ERR_NONE) begin
            close_value = 32'd0;
            close_count = 32'd0;
         end
         result.token_value  = close_value;
         result.repeat_count = close_count[30:0];
         result.parse_error  = close_error;
         result.buffer_done  = end_of_buffer;
         result_valid        = 1'b1;
         st                  = '0;
      end

      if (end_of_buffer) begin
         st = '0;
      end
      nxt_state = st;
   end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the repeat-count integer token parser.
// Drives text bytes into the parser, predicts every token result in the testbench itself
// and compares each result beat field by field. Depends on rcitp_pkg and the parser RTL.
module tb_top;

   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_VT    = 8'h0B;
   localparam logic [7:0]  CHAR_FF    = 8'h0C;
   localparam logic [7:0]  CHAR_HIGH  = 8'hFF;
   localparam logic [32:0] SAT_LIMIT  = 33'h0_8000_0001;
   localparam int          HOLD_CYCLES = 300;
   localparam int          TIMEOUT_CYCLES = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   rcitp_pkg::state_type   parser = '0;
   rcitp_pkg::result_type  expected_tokens[$];
   logic [7:0]  word[$];
   logic [7:0]  blanks[6] = '{rcitp_pkg::CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF,
                              rcitp_pkg::CHAR_CR, rcitp_pkg::CHAR_SPACE};

   int   send_idle_pct = 0;
   int   rsp_idle_pct = 0;
   logic hold_request = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   mismatch_count = 0;
   int   tokens_checked = 0;
   int   flagged_tokens = 0;
   int   bytes_sent = 0;
   int   buffers_sent = 0;

   repeat_count_integer_token_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == rcitp_pkg::CHAR_SPACE ||
             (ch >= rcitp_pkg::CHAR_TAB && ch <= rcitp_pkg::CHAR_CR);
   endfunction

   function automatic void add_char(input logic [7:0] ch);
      word = {word, ch};
   endfunction

   function automatic void note_error(input logic [1:0] code);
      if (parser.error_code == rcitp_pkg::ERR_NONE) parser.error_code = code;
   endfunction

   function automatic void restart_part();
      parser.number_phase  = rcitp_pkg::PHASE_START;
      parser.negative_sign = 1'b0;
      parser.accumulator   = '0;
   endfunction

   // Closes the current number part and gives its two's complement value.
   function automatic logic [31:0] finish_part();
      logic [32:0] bound;
      logic [31:0] mag;
      bound = parser.negative_sign ? rcitp_pkg::LIMIT_NEG : rcitp_pkg::LIMIT_POS;
      mag = parser.accumulator[31:0];
      if (parser.number_phase < rcitp_pkg::PHASE_DIGITS) note_error(rcitp_pkg::ERR_MISSING);
      else if (parser.accumulator > bound) note_error(rcitp_pkg::ERR_RANGE);
      return parser.negative_sign ? (32'd0 - mag) : mag;
   endfunction

   function automatic void parse_byte(input logic [7:0] ch, input logic last);
      logic        blank;
      logic [31:0] part_value;
      logic [31:0] count;
      logic [35:0] grown;
      rcitp_pkg::result_type token;
      blank = is_blank(ch);
      if (!blank) begin
         if (ch == rcitp_pkg::CHAR_STAR && parser.in_token && !parser.after_star) begin
            count = finish_part();
            parser.saved_count = count[31] ? 32'd0 : count;
            parser.after_star = 1'b1;
            restart_part();
         end else begin
            if (ch >= rcitp_pkg::CHAR_ZERO && ch <= rcitp_pkg::CHAR_NINE) begin
               if (parser.number_phase != rcitp_pkg::PHASE_STOPPED) begin
                  grown = {3'b000, parser.accumulator} * 36'd10 +
                          {28'd0, ch - rcitp_pkg::CHAR_ZERO};
                  parser.accumulator = (grown > {3'b000, SAT_LIMIT}) ? SAT_LIMIT : grown[32:0];
                  parser.number_phase = rcitp_pkg::PHASE_DIGITS;
               end
            end else if (parser.number_phase == rcitp_pkg::PHASE_START &&
                         (ch == rcitp_pkg::CHAR_PLUS || ch == rcitp_pkg::CHAR_MINUS)) begin
               parser.negative_sign = (ch == rcitp_pkg::CHAR_MINUS);
               parser.number_phase = rcitp_pkg::PHASE_SIGN;
            end else begin
               if (parser.number_phase < rcitp_pkg::PHASE_DIGITS)
                  note_error(rcitp_pkg::ERR_MISSING);
               parser.number_phase = rcitp_pkg::PHASE_STOPPED;
            end
            parser.in_token = 1'b1;
         end
      end
      if (parser.in_token && (blank || last)) begin
         part_value = finish_part();
         count = parser.after_star ? parser.saved_count : 32'd1;
         if (parser.error_code != rcitp_pkg::ERR_NONE) begin
            part_value = '0;
            count = '0;
         end
         token.token_value  = part_value;
         token.repeat_count = count[30:0];
         token.parse_error  = parser.error_code;
         token.buffer_done  = last;
         expected_tokens = {expected_tokens, token};
         parser = '0;
      end
      if (last) parser = '0;
   endfunction

   // Appends one number part: optional sign, digits (sometimes none, sometimes far too
   // many) and now and then a stray non-blank byte.
   function automatic void add_part();
      string near_limit;
      int    pick;
      int    digits;
      logic [7:0] junk;
      near_limit = "214748364";
      pick = $urandom_range(99);
      if (pick < 12) add_char(rcitp_pkg::CHAR_MINUS);
      else if (pick < 18) add_char(rcitp_pkg::CHAR_PLUS);
      pick = $urandom_range(99);
      if (pick < 5) begin
         for (int i = 0; i < near_limit.len(); i++) add_char(near_limit[i]);
         add_char(rcitp_pkg::CHAR_ZERO + 8'($urandom_range(6, 9)));
      end else begin
         if (pick < 11) digits = 0;
         else if (pick < 21) digits = $urandom_range(9, 12);
         else digits = $urandom_range(1, 3);
         for (int i = 0; i < digits; i++)
            add_char(rcitp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(9) == 0) begin
         do junk = 8'($urandom_range(255)); while (is_blank(junk));
         add_char(junk);
      end
   endfunction

   function automatic void build_token();
      logic [7:0] junk;
      word.delete();
      if ($urandom_range(99) < 40) begin
         add_part();
         add_char(rcitp_pkg::CHAR_STAR);
      end
      add_part();
      if (word.size() == 0) begin
         do junk = 8'($urandom_range(255)); while (is_blank(junk));
         add_char(junk);
      end
   endfunction

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_idle_pct <= receiver_pct;
   endtask

   task automatic send_byte(input logic [7:0] ch, input logic last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      parse_byte(ch, last);
      bytes_sent++;
      if (last) buffers_sent++;
   endtask

   task automatic send_word(input string text, input logic last);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], last && i == text.len() - 1);
   endtask

   // Sends the built token followed by one or two blanks; a buffer may end on the last
   // character of the token, and then no blank follows, or on the final blank.
   task automatic emit_token(input logic last);
      logic close_on_char;
      int   seps;
      close_on_char = last && $urandom_range(1);
      foreach (word[i]) send_byte(word[i], close_on_char && i == word.size() - 1);
      if (!close_on_char) begin
         seps = $urandom_range(1, 2);
         for (int k = 0; k < seps; k++) send_byte(blanks[$urandom_range(5)], last && k == seps - 1);
      end
   endtask

   task automatic test_directed_tokens();
      send_word("0 ", 1'b0);
      send_word("2147483647\t", 1'b0);
      send_word("-2147483648\n", 1'b0);
      send_word("2147483648 ", 1'b0);
      send_word("-2147483649\v", 1'b0);
      send_word("+7\f", 1'b0);
      send_word("3*5", 1'b0);
      send_byte(rcitp_pkg::CHAR_CR, 1'b0);
      send_word("-3*5 ", 1'b0);
      send_word("*5 ", 1'b0);
      send_word("3* ", 1'b0);
      send_word("- x ", 1'b0);
      send_word("3**5 12x*5 ", 1'b0);
      send_word("99999999999999*1 3*99999999999 ", 1'b0);
      send_word("-*4 2147483647*-2147483648 +0*+0 ", 1'b0);
      send_byte(CHAR_NUL, 1'b0);
      send_byte(rcitp_pkg::CHAR_SPACE, 1'b0);
      send_byte(CHAR_HIGH, 1'b0);
      send_word("7 ", 1'b0);
      send_word("42", 1'b1);
      send_word("  ", 1'b1);
      send_word("5 ", 1'b1);
      send_word("*", 1'b1);
   endtask

   task automatic test_random_tokens(input int byte_goal);
      int goal;
      goal = bytes_sent + byte_goal;
      while (bytes_sent < goal) begin
         if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
         end else begin
            build_token();
            emit_token($urandom_range(99) < 8);
         end
      end
   endtask

   // The receiver holds off for a long stretch while tokens keep coming, so the
   // result register fills and the parser stalls its input.
   task automatic test_output_stall();
      set_idling(0, 0);
      hold_request <= ~hold_request;
      repeat (40) begin
         build_token();
         emit_token(1'b0);
      end
      send_word("1*1", 1'b1);
   endtask

   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen  <= hold_request;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_tokens
      rcitp_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result beat: value %0d count %0d error %0d done %0b",
                        $signed(rsp_tdata[31:0]), rsp_tdata[62:32], rsp_tuser, rsp_tlast);
         end else begin
            want = expected_tokens.pop_front();
            tokens_checked++;
            if (want.parse_error != rcitp_pkg::ERR_NONE) flagged_tokens++;
            if (rsp_tdata[31:0] !== want.token_value || rsp_tdata[62:32] !== want.repeat_count ||
                rsp_tuser !== want.parse_error || rsp_tlast !== want.buffer_done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Token %0d: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                           tokens_checked, $signed(want.token_value), want.repeat_count,
                           want.parse_error, want.buffer_done, $signed(rsp_tdata[31:0]),
                           rsp_tdata[62:32], rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * 12);
      $display("repeat_count_integer_token_parser test failed");
      $finish;
   end

   initial begin
      set_idling(24, 48);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_tokens();
      test_random_tokens(240);
      set_idling(48, 24);
      test_random_tokens(240);
      test_output_stall();
      set_idling(0, 0);
      test_random_tokens(200);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d text bytes in %0d buffers under varied idling and a long output stall.",
               bytes_sent, buffers_sent);
      $display("Checked %0d tokens, %0d of them flagged as parse errors; %0d mismatches.",
               tokens_checked, flagged_tokens, mismatch_count);
      if (mismatch_count == 0 && expected_tokens.size() == 0)
         $display("repeat_count_integer_token_parser test passed");
      else
         $display("repeat_count_integer_token_parser test failed");
      $finish;
   end

endmodule
